/* src/skf_pkg.sv */
package skf_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 17;
    localparam int Q_W      = 24;
    localparam int R_W      = 32;
    localparam int VAR_W    = 32;
    localparam int DEN_W    = VAR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

    // Reset values
    localparam logic [Q_W-1:0]   Q_RESET   = 24'd655;     // ~0.01 in Q8.16
    localparam logic [R_W-1:0]   R_RESET   = 32'd655360;  // 10.0 in Q16.16
    localparam logic [VAR_W-1:0] VAR_RESET = 32'd65536;   // 1.0 in Q16.16

    // Unity gain in Q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // Sequencer controls shared by the serial units
    typedef struct packed {
        logic load;
        logic step;
    } skf_ctrl_t;

endpackage

/* src/skf_div.sv */
// Restoring divider, one quotient bit per cycle while step is high, MSB first.
// Quotient = floor(num * 2^(GAIN_W-1) / den), at most GAIN_W bits since num <= den.
module skf_div (
    input  logic                        aclk,
    input  skf_pkg::skf_ctrl_t          ctrl,
    input  logic [skf_pkg::VAR_W-1:0]   num,
    input  logic [skf_pkg::DEN_W-1:0]   den,
    input  logic                        den_zero,
    output logic                        q_bit,
    output logic [skf_pkg::GAIN_W-1:0]  quotient
);
    import skf_pkg::*;

    logic [DEN_W:0]    rem_reg;
    logic [DEN_W:0]    rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic              zero_reg;
    logic [GAIN_W-1:0] quo_reg;
    logic [DEN_W:0]    diff;
    logic [DEN_W-1:0]  rem_after;

    // Trial subtract; a zero divisor yields a zero quotient
    assign diff      = rem_reg - {1'b0, den_reg};
    assign q_bit     = !zero_reg && (rem_reg >= {1'b0, den_reg});
    assign rem_after = q_bit ? diff[DEN_W-1:0] : rem_reg[DEN_W-1:0];
    assign rem_next  = {rem_after, 1'b0};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            zero_reg <= den_zero;
            quo_reg  <= '0;
        end else if (ctrl.step) begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[GAIN_W-2:0], q_bit};
        end
    end

    assign quotient = quo_reg;

endmodule

/* src/skf_mac.sv */
// Bit-serial multiplier: multiplier bits arrive MSB first, acc = 2*acc + bit*a.
module skf_mac #(
    parameter int A_W = 40
) (
    input  logic                             aclk,
    input  skf_pkg::skf_ctrl_t               ctrl,
    input  logic                             mul_bit,
    input  logic [A_W-1:0]                   a,
    output logic [A_W+skf_pkg::GAIN_W-1:0]   product
);
    import skf_pkg::*;

    localparam int ACC_W = A_W + GAIN_W;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    assign acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                    + (mul_bit ? {{GAIN_W{1'b0}}, a} : {ACC_W{1'b0}});

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= '0;
        end else if (ctrl.step) begin
            acc_reg <= acc_next;
        end
    end

    assign product = acc_reg;

endmodule

/* src/scalar_kalman_filter.sv */
// Channel   Direction  Ports                                   Content
// s_        in         s_valid s_ready s_sample                one current sample
// m_        out        m_valid m_ready m_filtered m_gain_value rounded estimate, gain
// cfg_      in         cfg_we cfg_index cfg_data               noise register writes
//
// After transfer each sample passes ST_PREP, which predicts the variance and
// forms the error, ST_DENOM, which forms the divisor, ST_DIV for the bit-serial
// gain division (one quotient bit per cycle) and ST_UPD to update the state.
// The two products ride on the quotient bits as they come out of the divider.
// Reset (aresetn low, synchronous) restores the estimate, variance and noise settings.
// A result waiting in the output register does not block the next sample;
// the update step waits only if the previous result has not been taken.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [skf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [skf_pkg::SAMPLE_W-1:0] m_filtered,
    output logic [skf_pkg::GAIN_W-1:0]        m_gain_value
);
    import skf_pkg::*;

    localparam int EST_W = SAMPLE_W + FRAC_BITS;
    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(GAIN_W - 1);
    localparam logic [EST_W:0]   HALF     = (EST_W+1)'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DENOM = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [Q_W-1:0]             q_reg;
    logic [R_W-1:0]             r_reg;
    logic signed [EST_W-1:0]    est_reg;
    logic [VAR_W-1:0]           var_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [VAR_W-1:0]           p_reg;
    logic                       neg_reg;
    logic [EST_W-1:0]           mag_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_filt_reg;
    logic [GAIN_W-1:0]          out_gain_reg;

    logic                       in_xfer;
    logic                       upd_fire;
    logic [VAR_W:0]             p_sum;
    logic [VAR_W-1:0]           p_sat;
    logic [EST_W:0]             err;
    logic [EST_W:0]             err_abs;
    logic [DEN_W-1:0]           den;
    logic                       den_zero;
    skf_ctrl_t                  ctrl;
    logic                       q_bit;
    logic [GAIN_W-1:0]          gain;
    logic [EST_W+GAIN_W-1:0]    prod_e;
    logic [VAR_W+GAIN_W-1:0]    prod_v;
    logic [EST_W-1:0]           delta;
    logic [EST_W-1:0]           est_new;
    logic [VAR_W-1:0]           shrink;
    logic [VAR_W-1:0]           var_new;
    logic [EST_W:0]             rnd_sum;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign upd_fire = (state_reg == ST_UPD) && (!out_valid_reg || m_ready);

    // Prediction: saturating variance, error against the scaled sample
    assign p_sum   = {1'b0, var_reg} + {{(VAR_W+1-Q_W){1'b0}}, q_reg};
    assign p_sat   = p_sum[VAR_W] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];
    assign err     = {sample_reg[SAMPLE_W-1], sample_reg, {FRAC_BITS{1'b0}}}
                   - {est_reg[EST_W-1], est_reg};
    assign err_abs = err[EST_W] ? (~err + (EST_W+1)'(1)) : err;

    // Divisor for the gain
    assign den      = {1'b0, p_reg} + {1'b0, r_reg};
    assign den_zero = (p_reg == '0) && (r_reg == '0);

    assign ctrl.load = (state_reg == ST_DENOM);
    assign ctrl.step = (state_reg == ST_DIV);

    skf_div u_div (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .num      (p_reg),
        .den      (den),
        .den_zero (den_zero),
        .q_bit    (q_bit),
        .quotient (gain)
    );

    // gain * |err|
    skf_mac #(.A_W(EST_W)) u_mac_est (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .mul_bit (q_bit),
        .a       (mag_reg),
        .product (prod_e)
    );

    // gain * predicted variance
    skf_mac #(.A_W(VAR_W)) u_mac_var (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .mul_bit (q_bit),
        .a       (p_reg),
        .product (prod_v)
    );

    // Update: estimate moves by the truncated delta, variance = p - ceil(g*p/2^16)
    assign delta   = prod_e[EST_W+GAIN_W-2:GAIN_W-1];
    assign est_new = neg_reg ? (est_reg - delta) : (est_reg + delta);
    assign shrink  = prod_v[VAR_W+GAIN_W-2:GAIN_W-1]
                   + {{(VAR_W-1){1'b0}}, |prod_v[GAIN_W-2:0]};
    assign var_new = p_reg - shrink;
    assign rnd_sum = {est_new[EST_W-1], est_new} + HALF;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_DENOM;
            end
            ST_DENOM: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_BIT) state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_fire) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Noise settings and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= Q_RESET;
            r_reg   <= R_RESET;
            est_reg <= '0;
            var_reg <= VAR_RESET;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE:     q_reg <= cfg_data[Q_W-1:0];
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_data[R_W-1:0];
                    default: ;
                endcase
            end
            if (upd_fire) begin
                est_reg <= est_new;
                var_reg <= var_new;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= s_sample;
        end
        if (state_reg == ST_PREP) begin
            p_reg   <= p_sat;
            neg_reg <= err[EST_W];
            mag_reg <= err_abs[EST_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (upd_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_fire) begin
            out_filt_reg <= rnd_sum[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            out_gain_reg <= gain;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_filtered   = out_filt_reg;
    assign m_gain_value = out_gain_reg;

endmodule

/* src/skf_checker.sv */
module skf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [skf_pkg::SAMPLE_W-1:0] m_filtered,
    input logic [skf_pkg::GAIN_W-1:0]         m_gain_value
);
    import skf_pkg::*;

    // Result register is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // One sample in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after transfer");

    // Gain never exceeds unity
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gain_value <= GAIN_ONE))
        else $error("gain above 1.0");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_filtered) && $stable(m_gain_value)))
        else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_filtered   (m_filtered),
    .m_gain_value (m_gain_value)
);

/* tb/scalar_kalman_filter_tb.sv */
module scalar_kalman_filter_tb;
    import skf_pkg::*;

    localparam int FRAC         = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 800;

    typedef struct {
        logic signed [SAMPLE_W-1:0] filtered;
        logic [GAIN_W-1:0]          gain;
    } kf_out_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = REG_PROCESS_NOISE;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample  = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0]  m_filtered;
    logic [GAIN_W-1:0]           m_gain_value;

    // Filter state as the block should hold it
    logic [Q_W-1:0]              q_m        = Q_RESET;
    logic [R_W-1:0]              r_m        = R_RESET;
    logic signed [63:0]          est_m      = '0;
    logic [VAR_W-1:0]            variance_m = VAR_RESET;

    logic signed [SAMPLE_W-1:0]  sample_q[$];
    kf_out_t                     estimate_q[$];

    bit  idle_on     = 1'b1;
    int  in_wait     = 0;
    int  out_wait    = 0;
    int  out_draw;
    int  err_count   = 0;
    int  cycle_count = 0;

    scalar_kalman_filter #(.FRAC_BITS(FRAC)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_gain_value (m_gain_value)
    );

    always #6 aclk = ~aclk;

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %0s: got %0d, want %0d", what, got, want);
        err_count++;
    endtask

    // One filter step: predict, gain, move estimate, shrink variance
    task automatic advance_filter(input logic signed [SAMPLE_W-1:0] smp);
        logic [63:0]        pv, den, g, mag, dlt;
        logic signed [63:0] tgt, err, rnd;
        kf_out_t            res;
        pv = {32'd0, variance_m} + {40'd0, q_m};
        if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;    // saturate prediction
        den = pv + {32'd0, r_m};
        g = (den == 64'd0) ? 64'd0 : ((pv << 16) / den);
        if (g > 64'd65536) g = 64'd65536;
        tgt = smp;
        tgt = tgt <<< FRAC;
        err = tgt - est_m;
        mag = err[63] ? -err : err;
        dlt = (mag * g) >> 16;                          // truncated toward zero
        est_m = err[63] ? est_m - $signed(dlt) : est_m + $signed(dlt);
        variance_m = 32'(((64'd65536 - g) * pv) >> 16);
        rnd = (est_m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        res.filtered = rnd[SAMPLE_W-1:0];
        res.gain     = g[GAIN_W-1:0];
        estimate_q.push_back(res);
    endtask

    // Both noise registers, random order; block must be idle
    task automatic load_noise(input logic [31:0] qv, input logic [31:0] rv);
        bit q_first;
        q_first = $urandom_range(0, 1);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= q_first ? REG_PROCESS_NOISE : REG_MEASUREMENT_NOISE;
        cfg_data  <= q_first ? qv : rv;
        @(posedge aclk);
        cfg_index <= q_first ? REG_MEASUREMENT_NOISE : REG_PROCESS_NOISE;
        cfg_data  <= q_first ? rv : qv;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        q_m = qv[Q_W-1:0];
        r_m = rv;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_valid || estimate_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Input driver: holds each sample until transfer, gap before the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            if (s_valid && s_ready)
                advance_filter(s_sample);
            if (!s_valid || s_ready) begin
                if (in_wait != 0) begin
                    in_wait <= in_wait - 1;
                    s_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_q.pop_front();
                    in_wait  <= draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall counted from when a result shows up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            out_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_filtered, 0);
            end else begin
                kf_out_t want;
                want = estimate_q.pop_front();
                if (m_filtered !== want.filtered)
                    report_mismatch("filtered", m_filtered, want.filtered);
                if (m_gain_value !== want.gain)
                    report_mismatch("gain_value", m_gain_value, want.gain);
            end
            out_draw = draw_gap();
            out_wait <= out_draw;
            m_ready  <= (out_draw == 0);
        end else if (m_valid) begin
            if (out_wait <= 1) m_ready <= 1'b1;
            if (out_wait != 0) out_wait <= out_wait - 1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and run control
    initial begin
        int dir_default[8];
        int dir_max[5];
        int sent;
        int plen;
        int lvl;
        int mode;
        logic [31:0] qv, rv;

        dir_default = '{0, 8388607, 8388607, -8388608, -8388608, 1, -1, 0};
        dir_max     = '{8388607, -8388608, 0, 8388607, 12345};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset noise settings, full-scale and small samples
        foreach (dir_default[i]) sample_q.push_back(SAMPLE_W'(dir_default[i]));
        wait_idle();

        // No noise at all: unity gain, then the zero-denominator step
        load_noise(32'd0, 32'd0);
        sample_q.push_back(SAMPLE_W'(1234));
        sample_q.push_back(SAMPLE_W'(-4321));
        sample_q.push_back(SAMPLE_W'(8388607));
        wait_idle();

        // Largest process and measurement noise
        load_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (dir_max[i]) sample_q.push_back(SAMPLE_W'(dir_max[i]));
        wait_idle();

        // Tiny gain: no process noise, huge measurement noise
        load_noise(32'd0, 32'hFFFF_FFFF);
        sample_q.push_back(SAMPLE_W'(-8388608));
        sample_q.push_back(SAMPLE_W'(8388607));
        sample_q.push_back(SAMPLE_W'(7));
        sample_q.push_back(SAMPLE_W'(-7));
        wait_idle();

        // Exact measurements
        load_noise(32'h00FF_FFFF, 32'd0);
        sample_q.push_back(SAMPLE_W'(100));
        sample_q.push_back(SAMPLE_W'(-100));
        wait_idle();

        // Random phases: new noise settings, a sensor level with noise and outliers
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       qv = 32'd0;
                1:       qv = 32'hFFFF_FFFF;
                2:       qv = $urandom_range(0, 4096);
                3:       qv = $urandom;
                default: qv = $urandom_range(0, 1 << 20);
            endcase
            case ($urandom_range(0, 4))
                0:       rv = 32'd0;
                1:       rv = 32'hFFFF_FFFF;
                2:       rv = $urandom_range(0, 65536 * 16);
                3:       rv = $urandom;
                default: rv = $urandom_range(0, 4096);
            endcase
            load_noise(qv, rv);
            idle_on = ($urandom_range(0, 3) != 0);
            plen = $urandom_range(40, 120);
            lvl  = int'($urandom_range(0, 20000)) - 10000;
            for (int i = 0; i < plen; i++) begin
                mode = $urandom_range(0, 19);
                if (mode == 0)
                    sample_q.push_back($urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000);
                else if (mode < 4)
                    sample_q.push_back(SAMPLE_W'($urandom));
                else if (mode == 4)
                    lvl = int'($urandom_range(0, 200000)) - 100000;   // step change
                else
                    sample_q.push_back(SAMPLE_W'(lvl + int'($urandom_range(0, 2000)) - 1000));
            end
            sent += plen;
            wait_idle();
        end

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
